// File: design/swq_pkg.sv
// Shared types and constants for the sleep/wakeup timer queue.
// Used by the interfaces, the cell row, the top level and the checker.
package swq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int ID_W         = 6;
    localparam int TICK_W       = 32;
    localparam int KIND_W       = 3;

    localparam logic [KIND_W-1:0] KIND_ACCEPTED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IDLE_REFUSE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WOKEN       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOTHING_DUE = 3'd4;

    localparam logic MODE_SLEEP = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Per-cycle command to the cell row
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cmd;

endpackage

// File: design/swq_in_if.sv
// Input item channel: valid/ready handshake with mode, thread id and tick.
// Depends on swq_pkg for field widths.
interface swq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [swq_pkg::ID_W-1:0]      thread_id;
    logic [swq_pkg::TICK_W-1:0]    tick;

    modport source (output valid, output mode, output thread_id, output tick, input ready);
    modport sink   (input valid, input mode, input thread_id, input tick, output ready);
endinterface

// File: design/swq_out_if.sv
// Result channel: valid/ready handshake with kind, woken id and last marker.
// Depends on swq_pkg for field widths.
interface swq_out_if;
    logic                          valid;
    logic                          ready;
    logic [swq_pkg::KIND_W-1:0]    kind;
    logic [swq_pkg::ID_W-1:0]      woken_id;
    logic                          last;

    modport source (output valid, output kind, output woken_id, output last, input ready);
    modport sink   (input valid, input kind, input woken_id, input last, output ready);
endinterface

// File: design/swq_cfg_if.sv
// Configuration write channel carrying the idle thread id.
// Depends on swq_pkg for the id width.
interface swq_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [swq_pkg::ID_W-1:0]      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/sleep_wakeup_timer_queue_unit.sv
// Sleep/wakeup timer queue: top level with handshake control and result register.
// Depends on swq_pkg, the swq_*_if interfaces and swq_row.
//
// Usage:
//   i_in carries items: mode 0 asks to put thread_id to sleep until tick,
//   mode 1 is a timer tick carrying the current tick count.
//   o_out carries results: kind, woken_id and last (set on the final result
//   of an item). i_cfg writes the idle thread id; it is always ready.
// Timing and throughput:
//   A sleep, or a tick with nothing due, gives a single result that is valid
//   on the next cycle after its transfer. A tick with due threads first
//   enters the drain state and then drains one woken id per cycle, while the
//   output is free, from the head of the cell row, up to 16 per item; the
//   next item is taken after the last one is loaded. Sleep items sustain one
//   per cycle while the output is drained; the cell row shifts on insert or pop.
// Reset:
//   The queue becomes empty and the idle id returns to 0; cell contents are
//   not cleared.
// Backpressure:
//   A result holds in the output register until transferred; input ready
//   and the drain both stall while it waits.
module sleep_wakeup_timer_queue_unit #(
    parameter int DEPTH = swq_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swq_in_if.sink    i_in,
    swq_out_if.source o_out,
    swq_cfg_if.sink   i_cfg
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = $clog2(swq_pkg::RESULT_LIMIT);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic                        r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [NW-1:0]               r_pops, n_pops;
    logic [swq_pkg::TICK_W-1:0]  r_now, n_now;
    logic [swq_pkg::ID_W-1:0]    r_idle_id;
    logic                        r_o_valid, n_o_valid;
    logic [swq_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [swq_pkg::ID_W-1:0]    r_wid, n_wid;
    logic                        r_last, n_last;

    swq_pkg::t_cmd               w_cmd;
    logic [swq_pkg::ID_W-1:0]    w_front_id;
    logic [swq_pkg::TICK_W-1:0]  w_front_tick;
    logic [swq_pkg::TICK_W-1:0]  w_second_tick;
    logic                        w_out_free;
    logic                        w_fire;
    logic                        w_due;
    logic                        w_final;

    assign w_out_free = !r_o_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign w_due   = (r_count != '0) && (w_front_tick <= i_in.tick);
    // last pop of this tick: limit reached, queue runs dry, or next is later
    assign w_final = (r_pops == NW'(swq_pkg::RESULT_LIMIT - 1)) || (r_count == CW'(1))
                     || (w_second_tick > r_now);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pops    = r_pops;
        n_now     = r_now;
        n_o_valid = r_o_valid && !o_out.ready;
        n_kind    = r_kind;
        n_wid     = r_wid;
        n_last    = r_last;
        w_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    if (i_in.mode == swq_pkg::MODE_SLEEP) begin
                        n_o_valid = 1'b1;
                        n_wid     = '0;
                        n_last    = 1'b1;
                        if (i_in.thread_id == r_idle_id) begin
                            n_kind = swq_pkg::KIND_IDLE_REFUSE;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_kind = swq_pkg::KIND_FULL;
                        end else begin
                            n_kind    = swq_pkg::KIND_ACCEPTED;
                            w_cmd.ins = 1'b1;
                            n_count   = r_count + CW'(1);
                        end
                    end else if (w_due) begin
                        n_state = S_DRAIN;
                        n_now   = i_in.tick;
                        n_pops  = '0;
                    end else begin
                        n_o_valid = 1'b1;
                        n_kind    = swq_pkg::KIND_NOTHING_DUE;
                        n_wid     = '0;
                        n_last    = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    w_cmd.pop = 1'b1;
                    n_count   = r_count - CW'(1);
                    n_o_valid = 1'b1;
                    n_kind    = swq_pkg::KIND_WOKEN;
                    n_wid     = w_front_id;
                    n_last    = w_final;
                    n_pops    = r_pops + NW'(1);
                    if (w_final) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pops    <= '0;
            r_o_valid <= 1'b0;
            r_idle_id <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pops    <= n_pops;
            r_o_valid <= n_o_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_idle_id <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now  <= n_now;
        r_kind <= n_kind;
        r_wid  <= n_wid;
        r_last <= n_last;
    end

    swq_row #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_row (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_count       (r_count),
        .i_key_id      (i_in.thread_id),
        .i_key_tick    (i_in.tick),
        .o_front_id    (w_front_id),
        .o_front_tick  (w_front_tick),
        .o_second_tick (w_second_tick)
    );

    assign o_out.valid    = r_o_valid;
    assign o_out.kind     = r_kind;
    assign o_out.woken_id = r_wid;
    assign o_out.last     = r_last;

endmodule

// File: design/swq_cell.sv
// One slot of the sorted queue: holds an id and its wake tick.
// Shifts right on insert behind kept slots, left on pop. Depends on swq_pkg.
module swq_cell (
    input  logic                       i_clk,
    input  swq_pkg::t_cmd              i_cmd,
    input  logic                       i_occupied,
    input  logic                       i_prev_keep,
    input  logic [swq_pkg::ID_W-1:0]   i_key_id,
    input  logic [swq_pkg::TICK_W-1:0] i_key_tick,
    input  logic [swq_pkg::ID_W-1:0]   i_left_id,
    input  logic [swq_pkg::TICK_W-1:0] i_left_tick,
    input  logic [swq_pkg::ID_W-1:0]   i_right_id,
    input  logic [swq_pkg::TICK_W-1:0] i_right_tick,
    output logic                       o_keep,
    output logic [swq_pkg::ID_W-1:0]   o_id,
    output logic [swq_pkg::TICK_W-1:0] o_tick
);

    logic [swq_pkg::ID_W-1:0]   r_id;
    logic [swq_pkg::TICK_W-1:0] r_tick;

    // an occupied slot at or below the key stays put on insert
    assign o_keep = i_occupied && (r_tick <= i_key_tick);
    assign o_id   = r_id;
    assign o_tick = r_tick;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_id   <= i_right_id;
            r_tick <= i_right_tick;
        end else if (i_cmd.ins && !o_keep) begin
            if (i_prev_keep) begin
                r_id   <= i_key_id;
                r_tick <= i_key_tick;
            end else begin
                r_id   <= i_left_id;
                r_tick <= i_left_tick;
            end
        end
    end

endmodule

// File: design/swq_row.sv
// Row of DEPTH queue cells with neighbor links; exposes the front slot and the second slot's tick.
// Depends on swq_pkg and swq_cell.
module swq_row #(
    parameter int DEPTH = swq_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  swq_pkg::t_cmd              i_cmd,
    input  logic [CW-1:0]              i_count,
    input  logic [swq_pkg::ID_W-1:0]   i_key_id,
    input  logic [swq_pkg::TICK_W-1:0] i_key_tick,
    output logic [swq_pkg::ID_W-1:0]   o_front_id,
    output logic [swq_pkg::TICK_W-1:0] o_front_tick,
    output logic [swq_pkg::TICK_W-1:0] o_second_tick
);

    logic [DEPTH-1:0]           w_keep;
    logic [swq_pkg::ID_W-1:0]   w_id   [DEPTH];
    logic [swq_pkg::TICK_W-1:0] w_tick [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                       prev_keep;
        logic [swq_pkg::ID_W-1:0]   left_id, right_id;
        logic [swq_pkg::TICK_W-1:0] left_tick, right_tick;

        if (g == 0) begin : g_head
            assign prev_keep = 1'b1;
            assign left_id   = i_key_id;
            assign left_tick = i_key_tick;
        end else begin : g_body
            assign prev_keep = w_keep[g-1];
            assign left_id   = w_id[g-1];
            assign left_tick = w_tick[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_id   = w_id[g];
            assign right_tick = w_tick[g];
        end else begin : g_inner
            assign right_id   = w_id[g+1];
            assign right_tick = w_tick[g+1];
        end

        swq_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (i_cmd),
            .i_occupied   (i_count > CW'(g)),
            .i_prev_keep  (prev_keep),
            .i_key_id     (i_key_id),
            .i_key_tick   (i_key_tick),
            .i_left_id    (left_id),
            .i_left_tick  (left_tick),
            .i_right_id   (right_id),
            .i_right_tick (right_tick),
            .o_keep       (w_keep[g]),
            .o_id         (w_id[g]),
            .o_tick       (w_tick[g])
        );
    end

    assign o_front_id    = w_id[0];
    assign o_front_tick  = w_tick[0];
    assign o_second_tick = w_tick[1];

endmodule

// File: design/swq_checker.sv
// Port-level checks for the timer queue, bound to the top level.
// Depends on swq_pkg for kind codes and field widths.
module swq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_in_mode,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [swq_pkg::KIND_W-1:0] i_out_kind,
    input logic [swq_pkg::ID_W-1:0]   i_out_woken_id,
    input logic                       i_out_last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_woken_id) && $stable(i_out_last))
        else $error("stalled result changed");

    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != swq_pkg::KIND_WOKEN) |-> i_out_woken_id == '0)
        else $error("woken_id set on a non-wakeup result");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != swq_pkg::KIND_WOKEN) |-> i_out_last)
        else $error("single result not marked last");

    a_sleep_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_mode == swq_pkg::MODE_SLEEP)
            |=> i_out_valid && i_out_last && (i_out_kind != swq_pkg::KIND_WOKEN))
        else $error("sleep transfer not answered on the next cycle");

endmodule

bind sleep_wakeup_timer_queue_unit swq_checker u_swq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_mode      (i_in.mode),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_kind     (o_out.kind),
    .i_out_woken_id (o_out.woken_id),
    .i_out_last     (o_out.last)
);
